// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros used by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds now, consequent holds in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent holds now, consequent sequence starts in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("assertion failed");

`endif

// File: rtl/cips_pkg.sv
// ---------------------------------------------------------------------------
// cips_pkg
// constants, types and the side table of the checkbox icon pixel shader
// ---------------------------------------------------------------------------
package cips_pkg;

    localparam int COORD_W = 8;
    localparam int COLOR_W = 32;
    localparam int SIZE_W  = 3;
    localparam int SIDE_W  = 8;
    localparam int IDX_W   = 3;
    localparam int LIN_W   = 20;   // linear threshold terms
    localparam int DIFF_W  = 13;   // signed centre offsets, scaled by 10
    localparam int SQ_W    = 24;   // squared offsets and their sum

    // register indexes
    localparam logic [IDX_W-1:0] REG_SIZE_SELECT = 3'd0;
    localparam logic [IDX_W-1:0] REG_BACKGROUND  = 3'd1;
    localparam logic [IDX_W-1:0] REG_FOREGROUND  = 3'd2;
    localparam logic [IDX_W-1:0] REG_POSITIVE    = 3'd3;
    localparam logic [IDX_W-1:0] REG_NEGATIVE    = 3'd4;
    localparam logic [IDX_W-1:0] REG_UNCHECKED   = 3'd5;

    // size codes
    localparam logic [SIZE_W-1:0] SIZE_32  = 3'd0;
    localparam logic [SIZE_W-1:0] SIZE_64  = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_104 = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_152 = 3'd3;
    localparam logic [SIZE_W-1:0] SIZE_202 = 3'd4;

    // per-pixel classification carried down the pipe
    typedef struct packed {
        logic outside;   // margin, off the icon or no icon at all
        logic on_diag;   // on one of the cross stripes (circle not yet applied)
        logic on_tick;   // on either tick arm
    } shade_flags_t;

    function automatic logic [SIDE_W-1:0] side_of(input logic [SIZE_W-1:0] code);
        logic [SIDE_W-1:0] side;
        unique case (code)
            SIZE_32:  side = 8'd32;
            SIZE_64:  side = 8'd64;
            SIZE_104: side = 8'd104;
            SIZE_152: side = 8'd152;
            SIZE_202: side = 8'd202;
            default:  side = '0;
        endcase
        return side;
    endfunction

endpackage

// File: rtl/checkbox_icon_pixel_shader_unit.sv
// ---------------------------------------------------------------------------
// checkbox_icon_pixel_shader_unit
// shades one pixel of a square checkbox icon in its unchecked, ticked and
// crossed images
// ---------------------------------------------------------------------------
// An item (column, row) is taken on every clock edge where start is high;
// busy never rises, so one item per cycle is sustained. Each item gives one
// result, with done high for one cycle; the item reaches done through the
// four register stages, one after another in this order (input capture,
// threshold compares, squaring of the centre offsets, circle test and color
// select). The receiver cannot stall, so results leave in order and nothing
// is held back. Registers are written over the cfg port, which is always
// ready; write them only while no item is in flight. Index 0 is the size code
// (side 32, 64, 104, 152 or 202 pixels; codes 5 to 7 give an all-background
// icon), indexes 1 to 5 are the background, foreground, tick, cross and
// unchecked fill colors. Other indexes are ignored. A pixel off the icon or in
// the ten percent margin takes the background color in all three images.
// ---------------------------------------------------------------------------
module checkbox_icon_pixel_shader_unit
    import cips_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // item channel
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_W-1:0]    column,
    input  logic [COORD_W-1:0]    row,
    // result channel
    output logic                  done,
    output logic [COLOR_W-1:0]    unchecked_pixel,
    output logic [COLOR_W-1:0]    checked_pixel,
    output logic [COLOR_W-1:0]    crossed_pixel,
    // register write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [COLOR_W-1:0]    cfg_data
);

    // configuration registers
    logic [SIZE_W-1:0]  size_select_reg;
    logic [COLOR_W-1:0] background_reg;
    logic [COLOR_W-1:0] foreground_reg;
    logic [COLOR_W-1:0] positive_reg;
    logic [COLOR_W-1:0] negative_reg;
    logic [COLOR_W-1:0] unchecked_fill_reg;

    // stage 1: captured coordinates
    logic               v1_reg;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;

    // stage 2: linear compares and centre offsets
    logic                     v2_reg;
    shade_flags_t             flags2_reg;
    shade_flags_t             flags2_next;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [DIFF_W-1:0] dx_next;
    logic signed [DIFF_W-1:0] dy_next;
    logic [SIDE_W-1:0]        side2_reg;

    // stage 3: squares
    logic              v3_reg;
    shade_flags_t      flags3_reg;
    logic [SQ_W-1:0]   sqx_reg;
    logic [SQ_W-1:0]   sqy_reg;
    logic [SQ_W-1:0]   sqx_next;
    logic [SQ_W-1:0]   sqy_next;
    logic [2*SIDE_W-1:0] ss_reg;

    // stage 4: output
    logic               done_reg;
    logic [COLOR_W-1:0] unchecked_reg;
    logic [COLOR_W-1:0] checked_reg;
    logic [COLOR_W-1:0] crossed_reg;
    logic [COLOR_W-1:0] unchecked_next;
    logic [COLOR_W-1:0] checked_next;
    logic [COLOR_W-1:0] crossed_next;

    logic in_circle;

    // the pipe never stalls and the receiver cannot push back
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // register file
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_select_reg    <= '0;
            background_reg     <= '0;
            foreground_reg     <= '0;
            positive_reg       <= '0;
            negative_reg       <= '0;
            unchecked_fill_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SIZE_SELECT: size_select_reg    <= cfg_data[SIZE_W-1:0];
                REG_BACKGROUND:  background_reg     <= cfg_data;
                REG_FOREGROUND:  foreground_reg     <= cfg_data;
                REG_POSITIVE:    positive_reg       <= cfg_data;
                REG_NEGATIVE:    negative_reg       <= cfg_data;
                REG_UNCHECKED:   unchecked_fill_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 2 logic: every threshold is divided through by 100, 50 or 250
    // (the 251 and 1251 arm terms keep the scale of 1000) so that it is an exact integer compare against the side s
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [SIDE_W-1:0] side;
        logic              size_ok;
        logic [LIN_W-1:0]  s;
        logic [LIN_W-1:0]  c;
        logic [LIN_W-1:0]  r;
        logic [LIN_W-1:0]  c10;
        logic [LIN_W-1:0]  r10;
        logic [LIN_W-1:0]  cr;
        logic [LIN_W-1:0]  cr10;
        logic [LIN_W-1:0]  cr20;
        logic [LIN_W-1:0]  s5;
        logic              margin;
        logic              diag1;
        logic              diag2;
        logic              right_arm;
        logic              left_arm;
        logic [LIN_W-1:0]  dxw;
        logic [LIN_W-1:0]  dyw;

        side    = side_of(size_select_reg);
        size_ok = (size_select_reg <= SIZE_202);
        s       = LIN_W'(side);
        c       = LIN_W'(col_reg);
        r       = LIN_W'(row_reg);
        c10     = c * 20'd10;
        r10     = r * 20'd10;
        cr      = c + r;
        cr10    = cr * 20'd10;
        cr20    = cr * 20'd20;
        s5      = s * 20'd5;

        // ten percent margin and off-icon pixels
        margin = (c10 < s) || (c10 > s * 20'd9) ||
                 (r10 < s) || (r10 > s * 20'd9) ||
                 (c >= s) || (r >= s);

        // cross stripes, half width 0.1 around both diagonals
        diag1 = (c10 < r10 + s) && (c10 + s > r10);
        diag2 = (s * 20'd9 < cr10) && (s * 20'd11 > cr10);

        // tick arms
        right_arm = (s * 20'd21 < cr20) && (s5 > cr * 20'd4) &&
                    (c * 20'd20 < s * 20'd17) &&
                    (r * 20'd1000 < c * 20'd1000 + s * 20'd251);
        left_arm  = (c * 20'd4 + s < r * 20'd4) &&
                    (c * 20'd20 + s * 20'd9 > r * 20'd20) &&
                    (c * 20'd20 > s * 20'd3) &&
                    (cr * 20'd1000 < s * 20'd1251);

        flags2_next.outside = !size_ok || margin;
        flags2_next.on_diag = diag1 || diag2;
        flags2_next.on_tick = right_arm || left_arm;

        // centre offsets scaled by 10, they fit a signed 13-bit value
        dxw     = s5 - c10;
        dyw     = s5 - r10;
        dx_next = $signed(dxw[DIFF_W-1:0]);
        dy_next = $signed(dyw[DIFF_W-1:0]);
    end

    // stage 3 logic: one square per axis
    always_comb
    begin
        logic signed [SQ_W-1:0] dxe;
        logic signed [SQ_W-1:0] dye;
        logic signed [SQ_W-1:0] px;
        logic signed [SQ_W-1:0] py;

        dxe      = SQ_W'(dx_reg);
        dye      = SQ_W'(dy_reg);
        px       = dxe * dxe;
        py       = dye * dye;
        sqx_next = $unsigned(px);
        sqy_next = $unsigned(py);
    end

    // stage 4 logic: circle of radius 0.4 (40 s / 10 squared = 16 s^2) and color pick
    assign in_circle = (sqx_reg + sqy_reg) < {4'b0000, ss_reg, 4'b0000};

    always_comb
    begin
        if (flags3_reg.outside)
        begin
            unchecked_next = background_reg;
            checked_next   = background_reg;
            crossed_next   = background_reg;
        end
        else
        begin
            unchecked_next = unchecked_fill_reg;
            checked_next   = flags3_reg.on_tick ? positive_reg : foreground_reg;
            crossed_next   = (flags3_reg.on_diag && in_circle) ? negative_reg
                                                               : foreground_reg;
        end
    end

    // ------------------------------------------------------------------
    // valid bits travel with the data
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // payload stages, no reset needed
    always_ff @(posedge clk)
    begin
        col_reg       <= column;
        row_reg       <= row;
        flags2_reg    <= flags2_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        side2_reg     <= side_of(size_select_reg);
        flags3_reg    <= flags2_reg;
        sqx_reg       <= sqx_next;
        sqy_reg       <= sqy_next;
        ss_reg        <= side2_reg * side2_reg;
        unchecked_reg <= unchecked_next;
        checked_reg   <= checked_next;
        crossed_reg   <= crossed_next;
    end

    assign done            = done_reg;
    assign unchecked_pixel = unchecked_reg;
    assign checked_pixel   = checked_reg;
    assign crossed_pixel   = crossed_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `include "assert_macros.svh"

    // every accepted item comes out as a result
    `ASSERT_NEXT(a_item_latency, clk, rst_n, start && !busy, ##3 done)
    // no result without a matching accepted item earlier
    `ASSERT_SAME(a_no_phantom, clk, rst_n, done, $past(start && !busy, 4))
    // a pixel off the box shows the same color in all three images
    `ASSERT_NEXT(a_margin_uniform, clk, rst_n, v3_reg && flags3_reg.outside,
        (checked_pixel == unchecked_pixel) && (crossed_pixel == unchecked_pixel))

endmodule

// File: tb/sv/cips_shade_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cips_shade_checker
// watches the item, result and register channels of the checkbox icon pixel
// shader, works out the three state colors of every accepted pixel and
// compares them in order with the results that come out
// ---------------------------------------------------------------------------
module cips_shade_checker
    import cips_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [COORD_W-1:0] column,
    input  logic [COORD_W-1:0] row,
    input  logic               done,
    input  logic [COLOR_W-1:0] unchecked_pixel,
    input  logic [COLOR_W-1:0] checked_pixel,
    input  logic [COLOR_W-1:0] crossed_pixel,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [COLOR_W-1:0] cfg_data,
    output int                 mismatch_count,
    output int                 pixels_in_flight
);

    typedef struct packed {
        logic [COLOR_W-1:0] unchecked;
        logic [COLOR_W-1:0] checked;
        logic [COLOR_W-1:0] crossed;
    } shaded_pixel_t;

    // shadow copy of the register file
    logic [SIZE_W-1:0]  size_code;
    logic [COLOR_W-1:0] background;
    logic [COLOR_W-1:0] foreground;
    logic [COLOR_W-1:0] tick_color;
    logic [COLOR_W-1:0] cross_color;
    logic [COLOR_W-1:0] unchecked_fill;

    shaded_pixel_t expected_pixels[$];

    // all thresholds scaled by 1000 * side, so every compare is exact
    function automatic shaded_pixel_t shade_pixel(input logic [COORD_W-1:0] col,
                                                  input logic [COORD_W-1:0] rw);
        shaded_pixel_t px;
        longint s, xs, ys, dx, dy, rr, ix;
        bit on_icon, in_margin, diag_a, diag_b, in_circle, right_arm, left_arm;
        px = '{background, background, background};
        case (size_code)
            SIZE_32:  s = 32;
            SIZE_64:  s = 64;
            SIZE_104: s = 104;
            SIZE_152: s = 152;
            SIZE_202: s = 202;
            default:  s = 0;
        endcase
        if (s != 0) begin
            xs = 1000 * longint'(col);
            ys = 1000 * longint'(rw);
            on_icon = longint'(col) < s && longint'(rw) < s;
            in_margin = xs < 100 * s || xs > 900 * s || ys < 100 * s || ys > 900 * s;
            if (on_icon && !in_margin) begin
                dx = 500 * s - xs;
                dy = 500 * s - ys;
                rr = 400 * s;
                ix = 1000 * s - xs;
                diag_a = xs < ys + 100 * s && xs + 100 * s > ys;
                diag_b = ix < ys + 100 * s && ix + 100 * s > ys;
                in_circle = dx * dx + dy * dy < rr * rr;
                right_arm = (1250 * s - xs) < ys + 200 * s && (1250 * s - xs) > ys &&
                            xs < 850 * s && ys < xs + 251 * s;
                left_arm = xs + 500 * s < ys + 250 * s && xs + 500 * s > ys + 50 * s &&
                           xs > 150 * s && ys < 1251 * s - xs;
                px.unchecked = unchecked_fill;
                px.checked = (right_arm || left_arm) ? tick_color : foreground;
                px.crossed = ((diag_a || diag_b) && in_circle) ? cross_color : foreground;
            end
        end
        return px;
    endfunction

    function automatic int field_differs(input string name, input logic [COLOR_W-1:0] want,
                                         input logic [COLOR_W-1:0] got);
        if (got !== want) begin
            $error("%s expected %08h actual %08h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        int errs;
        shaded_pixel_t want;
        if (!rst_n) begin
            size_code      = '0;
            background     = '0;
            foreground     = '0;
            tick_color     = '0;
            cross_color    = '0;
            unchecked_fill = '0;
            expected_pixels.delete();
            pixels_in_flight <= 0;
            mismatch_count   <= 0;
        end
        else begin
            errs = 0;
            // results leave before this edge's item can be queued
            if (done) begin
                if (expected_pixels.size() == 0) begin
                    $error("result with no item waiting");
                    errs = errs + 1;
                end
                else begin
                    want = expected_pixels.pop_front();
                    errs = errs + field_differs("unchecked_pixel", want.unchecked,
                                                unchecked_pixel);
                    errs = errs + field_differs("checked_pixel", want.checked, checked_pixel);
                    errs = errs + field_differs("crossed_pixel", want.crossed, crossed_pixel);
                end
            end
            if (start && !busy)
                expected_pixels.push_back(shade_pixel(column, row));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SIZE_SELECT: size_code      = cfg_data[SIZE_W-1:0];
                    REG_BACKGROUND:  background     = cfg_data;
                    REG_FOREGROUND:  foreground     = cfg_data;
                    REG_POSITIVE:    tick_color     = cfg_data;
                    REG_NEGATIVE:    cross_color    = cfg_data;
                    REG_UNCHECKED:   unchecked_fill = cfg_data;
                    default: ;
                endcase
            end
            pixels_in_flight <= expected_pixels.size();
            mismatch_count   <= mismatch_count + errs;
        end
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// drives pixel items and register writes into the checkbox icon pixel shader
// across all size codes and a range of color sets; the checker beside the
// block predicts and compares, this module only makes stimulus and decides
// ---------------------------------------------------------------------------
module tb_top;
    import cips_pkg::*;

    // pipeline depth given by the block, plus some slack before reconfiguring
    localparam int LATENCY         = 4;
    localparam int DRAIN_CYCLES    = LATENCY + 4;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 153;
    // longest quiet stretch: an idle gap, a drain and the pause after it
    localparam int WATCHDOG_LIMIT  = 1000;

    // indexes past the register list, written to show they are ignored
    localparam logic [IDX_W-1:0]  REG_SPARE_6   = 3'd6;
    localparam logic [IDX_W-1:0]  REG_SPARE_7   = 3'd7;
    // size codes with no icon behind them
    localparam logic [SIZE_W-1:0] SIZE_UNUSED_5 = 3'd5;
    localparam logic [SIZE_W-1:0] SIZE_UNUSED_6 = 3'd6;
    localparam logic [SIZE_W-1:0] SIZE_UNUSED_7 = 3'd7;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    logic [COORD_W-1:0] column    = '0;
    logic [COORD_W-1:0] row       = '0;
    logic               done;
    logic [COLOR_W-1:0] unchecked_pixel;
    logic [COLOR_W-1:0] checked_pixel;
    logic [COLOR_W-1:0] crossed_pixel;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [COLOR_W-1:0] cfg_data  = '0;

    int mismatch_count;
    int pixels_in_flight;
    int quiet_cycles = 0;
    bit idle_enabled = 1'b1;

    checkbox_icon_pixel_shader_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .column          (column),
        .row             (row),
        .done            (done),
        .unchecked_pixel (unchecked_pixel),
        .checked_pixel   (checked_pixel),
        .crossed_pixel   (crossed_pixel),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    cips_shade_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .column           (column),
        .row              (row),
        .done             (done),
        .unchecked_pixel  (unchecked_pixel),
        .checked_pixel    (checked_pixel),
        .crossed_pixel    (crossed_pixel),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .pixels_in_flight (pixels_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: any accepted item, result or register write restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // size code used in each phase: both extremes, every side, every unused code
    function automatic logic [SIZE_W-1:0] phase_size(input int phase);
        case (phase)
            0:       return SIZE_202;
            1:       return SIZE_32;
            2:       return SIZE_64;
            3:       return SIZE_104;
            4:       return SIZE_152;
            5:       return SIZE_UNUSED_5;
            6:       return SIZE_202;
            7:       return SIZE_32;
            8:       return SIZE_UNUSED_7;
            9:       return SIZE_UNUSED_6;
            10:      return SIZE_152;
            default: return SIZE_202;
        endcase
    endfunction

    // icon side in pixels, 0 where the code has no icon
    function automatic int icon_side(input logic [SIZE_W-1:0] code);
        case (code)
            SIZE_32:  return 32;
            SIZE_64:  return 64;
            SIZE_104: return 104;
            SIZE_152: return 152;
            SIZE_202: return 202;
            default:  return 0;
        endcase
    endfunction

    // one register write; the channel may idle for a burst before it
    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // one pixel item; start stays high into the next item unless a gap is drawn
    task automatic shade_item(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r);
        if (idle_enabled && $urandom_range(0, 4) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        start  <= 1'b1;
        column <= c;
        row    <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // hold off until every expected result is back, then let the pipe settle
    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge clk);
        while (pixels_in_flight != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register set of one phase: two fixed sets at the color extremes, the
    // rest random; the spare indexes get junk that must change nothing
    task automatic load_phase(input int phase);
        logic [COLOR_W-1:0] bg, fg, tick, mark, fill, size_word;
        case (phase)
            2:
            begin
                bg = 32'h0000_0000; fg = 32'hFFFF_FFFF; tick = 32'hFFFF_0000;
                mark = 32'h0000_FFFF; fill = 32'h8080_8080;
            end
            6:
            begin
                bg = 32'hFFFF_FFFF; fg = 32'h0000_0000; tick = 32'h0000_FFFF;
                mark = 32'hFFFF_0000; fill = 32'h7F7F_7F7F;
            end
            default:
            begin
                bg = $urandom; fg = $urandom; tick = $urandom;
                mark = $urandom; fill = $urandom;
            end
        endcase
        // upper bits of the size word are random and must be dropped
        size_word = $urandom;
        size_word[SIZE_W-1:0] = phase_size(phase);
        write_register(REG_SPARE_6, $urandom);
        write_register(REG_SIZE_SELECT, size_word);
        write_register(REG_BACKGROUND, bg);
        write_register(REG_FOREGROUND, fg);
        write_register(REG_POSITIVE, tick);
        write_register(REG_NEGATIVE, mark);
        write_register(REG_UNCHECKED, fill);
        write_register(REG_SPARE_7, $urandom);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int side;
        logic [COORD_W-1:0] c, r;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // no idling in the last part, and one earlier stretch without it
            idle_enabled = (phase < PHASES - 3) && (phase != 3);
            load_phase(phase);
            side = icon_side(phase_size(phase));

            if (phase == 0)
            begin
                // directed pixels on the 202 icon
                shade_item(8'd0, 8'd0);        // corner, both fields low
                shade_item(8'd255, 8'd255);    // both fields at their top
                shade_item(8'd0, 8'd255);
                shade_item(8'd255, 8'd0);
                shade_item(8'd201, 8'd201);    // last pixel on the icon
                shade_item(8'd202, 8'd100);    // first column off the icon
                shade_item(8'd100, 8'd202);    // first row off the icon
                shade_item(8'd20, 8'd20);      // just inside the top-left margin
                shade_item(8'd21, 8'd21);      // first inner pixel, on a stripe
                shade_item(8'd181, 8'd181);    // last inner pixel
                shade_item(8'd182, 8'd100);    // right margin edge
                shade_item(8'd101, 8'd101);    // centre, both stripes cross
                shade_item(8'd161, 8'd41);     // second stripe near the circle rim
                shade_item(8'd121, 8'd111);    // on the right tick arm
                shade_item(8'd61, 8'd131);     // on the left tick arm
                shade_item(8'd171, 8'd171);    // on a stripe, outside the circle
                shade_item(8'd85, 8'd160);     // near where the tick arms meet
                shade_item(8'd40, 8'd100);     // on the left tick arm
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // mostly pixels on the icon, the rest anywhere in the field range
                if (side != 0 && $urandom_range(0, 99) < 85)
                begin
                    c = COORD_W'($urandom_range(0, side - 1));
                    r = COORD_W'($urandom_range(0, side - 1));
                end
                else
                begin
                    c = COORD_W'($urandom_range(0, 255));
                    r = COORD_W'($urandom_range(0, 255));
                end
                shade_item(c, r);
            end

            // registers only change with nothing in flight
            wait_for_drain();
        end

        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
